// ----- sv/plob_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plob_pkg
// Shared types, codes and default sizes of the price level order book.
// ----------------------------------------------------------------------------
package plob_pkg;

    localparam int PRICE_LEVELS_DEF = 1024;
    localparam int LEVEL_DEPTH_DEF  = 16;
    localparam int WORD_BITS_DEF    = 64;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_CANCEL = 2'd1;
    localparam logic [1:0] CMD_FILL   = 2'd2;

    localparam logic [23:0] AMOUNT_MAX = 24'd65535;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_BEYOND  = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_EXHAUST = 3'd3;
    localparam logic [2:0] ST_TOOBIG  = 3'd4;

    typedef enum logic [1:0] {
        KIND_ADD,
        KIND_CANCEL,
        KIND_FILL,
        KIND_IMM
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  imm;
        logic [9:0]  price;
        logic [23:0] amount;
        logic [13:0] position;
    } t_item;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD_RD,
        S_ADD_CHK,
        S_CW,
        S_CB,
        S_CM,
        S_SH,
        S_SHW,
        S_CFIN,
        S_FW,
        S_FB,
        S_FM,
        S_FR,
        S_FT,
        S_FA,
        S_FC,
        S_OUT
    } t_bstate;

endpackage

// ----- sv/price_level_order_book_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// price_level_order_book_top
// Limit order book with one FIFO of order amounts per price level.
//
// Input channel (i_valid / o_ready): command, price, amount, position.
// Output channel (o_valid / i_ready): status, filled, cost; one word per
// command, in command order.
// A two-entry queue decouples acceptance from execution, so up to two
// commands are taken while a result word waits for the receiver.
// Immediate cases (oversized add, bad add price, zero fill, unknown
// command) are settled in the front end. Cancel walks the occupancy
// words and occupied levels to the order and shifts the orders behind
// it; fill scans for occupied levels and consumes orders level by level.
// The back end serves one command at a time.
// After reset the level table is cleared, one level per cycle; o_ready
// stays low during that pass.
// While i_ready is low the result word holds and the back end waits.
// ----------------------------------------------------------------------------
module price_level_order_book_top #(
    parameter int PRICE_LEVELS = plob_pkg::PRICE_LEVELS_DEF,
    parameter int LEVEL_DEPTH  = plob_pkg::LEVEL_DEPTH_DEF,
    parameter int WORD_BITS    = plob_pkg::WORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_command,
    input  logic [9:0]  i_price,
    input  logic [23:0] i_amount,
    input  logic [13:0] i_position,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [23:0] o_filled,
    output logic [33:0] o_cost
);
    import plob_pkg::*;

    t_item w_item;
    logic  w_item_valid;
    logic  w_item_pop;
    logic  w_busy;

    plob_front #(
        .PRICE_LEVELS(PRICE_LEVELS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_command    (i_command),
        .i_price      (i_price),
        .i_amount     (i_amount),
        .i_position   (i_position),
        .i_busy       (w_busy),
        .o_item       (w_item),
        .o_item_valid (w_item_valid),
        .i_item_pop   (w_item_pop)
    );

    plob_back #(
        .PRICE_LEVELS(PRICE_LEVELS),
        .LEVEL_DEPTH (LEVEL_DEPTH),
        .WORD_BITS   (WORD_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_item),
        .i_item_valid (w_item_valid),
        .o_item_pop   (w_item_pop),
        .o_busy       (w_busy),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_status     (o_status),
        .o_filled     (o_filled),
        .o_cost       (o_cost)
    );

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !o_ready && !o_valid)
        else $error("input taken during level clear");

    a_cost_needs_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_filled == 24'd0) |-> o_cost == 34'd0)
        else $error("cost without filled quantity");

    a_reject_no_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_FULL || o_status == ST_BEYOND ||
                     o_status == ST_TOOBIG)) |-> o_filled == 24'd0)
        else $error("rejected command reports a fill");

    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_item_pop |-> w_item_valid && !o_valid)
        else $error("queue popped while result pending");

endmodule

// ----- sv/plob_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plob_front
// Accepts command words, settles the cases that need no book state, and
// queues every command, settled or not, for the back end in a two-entry queue.
// ----------------------------------------------------------------------------
module plob_front #(
    parameter int PRICE_LEVELS = plob_pkg::PRICE_LEVELS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_command,
    input  logic [9:0]       i_price,
    input  logic [23:0]      i_amount,
    input  logic [13:0]      i_position,
    input  logic             i_busy,
    output plob_pkg::t_item  o_item,
    output logic             o_item_valid,
    input  logic             i_item_pop
);
    import plob_pkg::*;

    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_item      w_item;
    logic       w_push;

    always_comb begin
        w_item.price    = i_price;
        w_item.amount   = i_amount;
        w_item.position = i_position;
        w_item.imm      = ST_OK;
        w_item.kind     = KIND_IMM;
        case (i_command)
            CMD_ADD: begin
                if (i_amount > AMOUNT_MAX) begin
                    w_item.imm = ST_TOOBIG;
                end else if (32'(i_price) >= PRICE_LEVELS) begin
                    w_item.imm = ST_BEYOND;
                end else begin
                    w_item.kind = KIND_ADD;
                end
            end
            CMD_CANCEL: w_item.kind = KIND_CANCEL;
            CMD_FILL: begin
                if (i_amount != 24'd0) begin
                    w_item.kind = KIND_FILL;
                end
            end
            default: w_item.kind = KIND_IMM;
        endcase
    end

    assign o_ready      = (r_cnt != 2'd2) && !i_busy;
    assign w_push       = i_valid && o_ready;
    assign o_item_valid = (r_cnt != 2'd0);
    assign o_item       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_item_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_item_pop);
        end
    end

endmodule

// ----- sv/plob_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plob_back
// Executes add, cancel and fill against the level queues, the occupancy
// bitmap and the order counts, and holds the result word for the receiver.
// ----------------------------------------------------------------------------
module plob_back #(
    parameter int PRICE_LEVELS = plob_pkg::PRICE_LEVELS_DEF,
    parameter int LEVEL_DEPTH  = plob_pkg::LEVEL_DEPTH_DEF,
    parameter int WORD_BITS    = plob_pkg::WORD_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  plob_pkg::t_item i_item,
    input  logic            i_item_valid,
    output logic            o_item_pop,
    output logic            o_busy,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [2:0]      o_status,
    output logic [23:0]     o_filled,
    output logic [33:0]     o_cost
);
    import plob_pkg::*;

    localparam int LB   = $clog2(PRICE_LEVELS);
    localparam int SB   = $clog2(LEVEL_DEPTH);
    localparam int CB   = $clog2(LEVEL_DEPTH + 1);
    localparam int NW   = (PRICE_LEVELS + WORD_BITS - 1) / WORD_BITS;
    localparam int WIB  = (NW > 1) ? $clog2(NW) : 1;
    localparam int JI   = $clog2(WORD_BITS);
    localparam int JB   = $clog2(WORD_BITS + 1);
    localparam int WCB  = $clog2(WORD_BITS * LEVEL_DEPTH + 1);
    localparam int TB   = $clog2(PRICE_LEVELS * LEVEL_DEPTH + 1);
    localparam int POSB = (TB > 14) ? TB : 14;
    localparam int AB   = LB + SB;
    localparam int AD   = PRICE_LEVELS * (2 ** SB);
    localparam int MW   = 2 * SB + CB;
    localparam int PB   = 16 + LB;

    logic [15:0]   mem_amt  [AD];
    logic [MW-1:0] mem_meta [PRICE_LEVELS];

    t_bstate        r_state, n_state;
    logic [LB-1:0]  r_lvl, n_lvl;
    logic [WIB-1:0] r_w, n_w;
    logic [JI-1:0]  r_bit, n_bit;
    logic [JB-1:0]  r_j, n_j;
    logic [POSB-1:0] r_pos, n_pos;
    logic [CB-1:0]  r_k, n_k;
    logic [SB-1:0]  r_head, n_head;
    logic [SB-1:0]  r_tail, n_tail;
    logic [CB-1:0]  r_cnt, n_cnt;
    logic [23:0]    r_qty, n_qty;
    logic [15:0]    r_amt, n_amt;
    logic [15:0]    r_take, n_take;
    logic [PB-1:0]  r_prod, n_prod;
    logic [23:0]    r_filled, n_filled;
    logic [33:0]    r_cost, n_cost;
    logic [2:0]     r_status, n_status;
    logic [WORD_BITS-1:0] r_occ  [NW];
    logic [WORD_BITS-1:0] n_occ  [NW];
    logic [WCB-1:0] r_wcnt [NW];
    logic [WCB-1:0] n_wcnt [NW];
    logic [TB-1:0]  r_total, n_total;

    logic [15:0]    r_amt_rd;
    logic [MW-1:0]  r_meta_rd;
    logic [AB-1:0]  amt_raddr, amt_waddr;
    logic           amt_we;
    logic [15:0]    amt_wdata;
    logic [LB-1:0]  meta_raddr, meta_waddr;
    logic           meta_we;
    logic [MW-1:0]  meta_wdata;

    logic [SB-1:0]  rd_head, rd_tail;
    logic [CB-1:0]  rd_cnt;
    logic [JI-1:0]  f_idx;
    logic [LB-1:0]  f_lvl;
    logic [23:0]    w_take;
    logic [15:0]    w_front;
    logic [CB:0]    w_k1;

    function automatic logic [SB-1:0] slot_add(input logic [SB-1:0] h, input logic [CB-1:0] k);
        logic [SB+CB:0] s;
        s = (SB + CB + 1)'(h) + (SB + CB + 1)'(k);
        if (s >= (SB + CB + 1)'(LEVEL_DEPTH)) begin
            s = s - (SB + CB + 1)'(LEVEL_DEPTH);
        end
        return SB'(s);
    endfunction

    function automatic logic [SB-1:0] slot_inc(input logic [SB-1:0] h);
        return (h == SB'(LEVEL_DEPTH - 1)) ? '0 : h + SB'(1);
    endfunction

    function automatic logic [SB-1:0] slot_dec(input logic [SB-1:0] h);
        return (h == '0) ? SB'(LEVEL_DEPTH - 1) : h - SB'(1);
    endfunction

    assign rd_head = r_meta_rd[MW-1 -: SB];
    assign rd_tail = r_meta_rd[CB+SB-1 -: SB];
    assign rd_cnt  = r_meta_rd[CB-1:0];
    assign w_k1    = (CB + 1)'(r_k) + (CB + 1)'(1);

    always_comb begin
        f_idx   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (r_occ[r_w][i] && (JB'(i) >= r_j)) begin
                f_idx   = JI'(i);
            end
        end
        f_lvl = LB'(int'(r_w) * WORD_BITS + int'(f_idx));
    end

    assign w_take  = (24'(r_amt_rd) < r_qty) ? 24'(r_amt_rd) : r_qty;
    assign w_front = r_amt_rd - 16'(w_take);

    always_ff @(posedge i_clk) begin
        if (amt_we) begin
            mem_amt[amt_waddr] <= amt_wdata;
        end
        r_amt_rd <= mem_amt[amt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            mem_meta[meta_waddr] <= meta_wdata;
        end
        r_meta_rd <= mem_meta[meta_raddr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:   if (r_lvl == LB'(PRICE_LEVELS - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (i_item_valid) begin
                    case (i_item.kind)
                        KIND_ADD:    n_state = S_ADD_RD;
                        KIND_CANCEL: n_state = (POSB'(i_item.position) >= POSB'(r_total))
                                               ? S_OUT : S_CW;
                        KIND_FILL:   n_state = (r_total == '0) ? S_OUT : S_FW;
                        default:     n_state = S_OUT;
                    endcase
                end
            end
            S_ADD_RD:  n_state = S_ADD_CHK;
            S_ADD_CHK: n_state = S_OUT;
            S_CW:      if (r_pos < POSB'(r_wcnt[r_w])) n_state = S_CB;
            S_CB:      n_state = S_CM;
            S_CM:      n_state = (r_pos < POSB'(rd_cnt)) ? S_SH : S_CB;
            S_SH:      n_state = (w_k1 < (CB + 1)'(r_cnt)) ? S_SHW : S_CFIN;
            S_SHW:     n_state = S_SH;
            S_CFIN:    n_state = S_OUT;
            S_FW:      if (r_occ[r_w] != '0) n_state = S_FB;
            S_FB:      n_state = S_FM;
            S_FM:      n_state = S_FR;
            S_FR:      n_state = S_FT;
            S_FT:      n_state = S_FA;
            S_FA:      n_state = S_FC;
            S_FC: begin
                if (r_qty == '0) begin
                    n_state = S_OUT;
                end else if (r_cnt != '0) begin
                    n_state = S_FR;
                end else if (r_total == '0) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_FW;
                end
            end
            S_OUT:     if (i_ready) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_busy     = (r_state == S_CLEAR);
        o_valid    = (r_state == S_OUT);
        o_item_pop = (r_state == S_IDLE) && i_item_valid;
        amt_raddr  = {r_lvl, r_head};
        amt_we     = 1'b0;
        amt_waddr  = {r_lvl, r_head};
        amt_wdata  = w_front;
        meta_raddr = r_lvl;
        meta_we    = 1'b0;
        meta_waddr = r_lvl;
        meta_wdata = {r_head, r_tail, r_cnt};
        case (r_state)
            S_CLEAR: begin
                meta_we    = 1'b1;
                meta_wdata = '0;
            end
            S_ADD_CHK: begin
                if (rd_cnt < CB'(LEVEL_DEPTH)) begin
                    amt_we     = 1'b1;
                    amt_waddr  = {r_lvl, rd_tail};
                    amt_wdata  = r_amt;
                    meta_we    = 1'b1;
                    meta_wdata = {rd_head, slot_inc(rd_tail), rd_cnt + CB'(1)};
                end
            end
            S_CB: meta_raddr = f_lvl;
            S_FB: meta_raddr = f_lvl;
            S_SH: amt_raddr = {r_lvl, slot_add(r_head, CB'(w_k1))};
            S_SHW: begin
                amt_we    = 1'b1;
                amt_waddr = {r_lvl, slot_add(r_head, r_k)};
                amt_wdata = r_amt_rd;
            end
            S_CFIN: begin
                meta_we    = 1'b1;
                meta_wdata = {r_head, slot_dec(r_tail), r_cnt - CB'(1)};
            end
            S_FT: amt_we = (w_front != '0);
            S_FC: meta_we = (r_qty == '0) || (r_cnt == '0);
            default: amt_we = 1'b0;
        endcase
    end

    always_comb begin
        n_lvl    = r_lvl;
        n_w      = r_w;
        n_bit    = r_bit;
        n_j      = r_j;
        n_pos    = r_pos;
        n_k      = r_k;
        n_head   = r_head;
        n_tail   = r_tail;
        n_cnt    = r_cnt;
        n_qty    = r_qty;
        n_amt    = r_amt;
        n_take   = r_take;
        n_prod   = r_prod;
        n_filled = r_filled;
        n_cost   = r_cost;
        n_status = r_status;
        n_occ    = r_occ;
        n_wcnt   = r_wcnt;
        n_total  = r_total;
        case (r_state)
            S_CLEAR: n_lvl = r_lvl + LB'(1);
            S_IDLE: begin
                n_filled = '0;
                n_cost   = '0;
                n_status = ST_OK;
                n_w      = '0;
                n_j      = '0;
                n_lvl    = LB'(i_item.price);
                n_w      = WIB'(32'(i_item.price) / WORD_BITS);
                n_bit    = JI'(32'(i_item.price) % WORD_BITS);
                n_amt    = i_item.amount[15:0];
                n_qty    = i_item.amount;
                n_pos    = POSB'(i_item.position);
                case (i_item.kind)
                    KIND_CANCEL: begin
                        n_w = '0;
                        if (POSB'(i_item.position) >= POSB'(r_total)) n_status = ST_BEYOND;
                    end
                    KIND_FILL: begin
                        n_w = '0;
                        if (r_total == '0) n_status = ST_EXHAUST;
                    end
                    KIND_IMM: n_status = i_item.imm;
                    default:  n_status = ST_OK;
                endcase
            end
            S_ADD_CHK: begin
                if (rd_cnt >= CB'(LEVEL_DEPTH)) begin
                    n_status = ST_FULL;
                end else begin
                    n_wcnt[r_w]       = r_wcnt[r_w] + WCB'(1);
                    n_total           = r_total + TB'(1);
                    n_occ[r_w][r_bit] = 1'b1;
                end
            end
            S_CW: begin
                if (r_pos < POSB'(r_wcnt[r_w])) begin
                    n_j = '0;
                end else begin
                    n_pos = r_pos - POSB'(r_wcnt[r_w]);
                    n_w   = r_w + WIB'(1);
                end
            end
            S_CB: begin
                n_lvl = f_lvl;
                n_bit = f_idx;
                n_j   = JB'(f_idx) + JB'(1);
            end
            S_CM: begin
                if (r_pos < POSB'(rd_cnt)) begin
                    n_k    = CB'(r_pos);
                    n_head = rd_head;
                    n_tail = rd_tail;
                    n_cnt  = rd_cnt;
                end else begin
                    n_pos = r_pos - POSB'(rd_cnt);
                end
            end
            S_SHW: n_k = r_k + CB'(1);
            S_CFIN: begin
                n_wcnt[r_w] = r_wcnt[r_w] - WCB'(1);
                n_total     = r_total - TB'(1);
                if (r_cnt == CB'(1)) n_occ[r_w][r_bit] = 1'b0;
            end
            S_FW: begin
                n_j = '0;
                if (r_occ[r_w] == '0) n_w = r_w + WIB'(1);
            end
            S_FB: begin
                n_lvl = f_lvl;
                n_bit = f_idx;
            end
            S_FM: begin
                n_head = rd_head;
                n_tail = rd_tail;
                n_cnt  = rd_cnt;
            end
            S_FT: begin
                n_take   = w_take[15:0];
                n_qty    = r_qty - w_take;
                n_filled = r_filled + w_take;
                if (w_front == '0) begin
                    n_head      = slot_inc(r_head);
                    n_cnt       = r_cnt - CB'(1);
                    n_wcnt[r_w] = r_wcnt[r_w] - WCB'(1);
                    n_total     = r_total - TB'(1);
                end
            end
            S_FA: n_prod = PB'(r_take) * PB'(r_lvl);
            S_FC: begin
                n_cost = r_cost + 34'(r_prod);
                if (r_cnt == '0) n_occ[r_w][r_bit] = 1'b0;
                if (r_qty != '0 && r_cnt == '0 && r_total == '0) n_status = ST_EXHAUST;
            end
            default: n_lvl = r_lvl;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_w      <= n_w;
        r_bit    <= n_bit;
        r_j      <= n_j;
        r_pos    <= n_pos;
        r_k      <= n_k;
        r_head   <= n_head;
        r_tail   <= n_tail;
        r_cnt    <= n_cnt;
        r_qty    <= n_qty;
        r_amt    <= n_amt;
        r_take   <= n_take;
        r_prod   <= n_prod;
        r_filled <= n_filled;
        r_cost   <= n_cost;
        r_status <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_lvl   <= '0;
            r_total <= '0;
            for (int i = 0; i < NW; i++) begin
                r_occ[i]  <= '0;
                r_wcnt[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_lvl   <= n_lvl;
            r_total <= n_total;
            r_occ   <= n_occ;
            r_wcnt  <= n_wcnt;
        end
    end

    assign o_status = r_status;
    assign o_filled = r_filled;
    assign o_cost   = r_cost;

endmodule

// ----- tb/sv/price_level_order_book_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// price_level_order_book_top_tb
// Self-checking bench for the price level order book. A scoreboard keeps
// its own book of per-level queues, predicts status, filled and cost for
// every accepted command, and compares each result word in order. Directed
// corner cases come first, then random command traffic with bursty input
// and a receiver that stalls on a changing pattern.
// ----------------------------------------------------------------------------
module price_level_order_book_top_tb;
    import plob_pkg::*;

    localparam logic [1:0] CMD_NONE   = 2'd3;
    localparam int         N_LEVELS   = PRICE_LEVELS_DEF;
    localparam int         Q_DEPTH    = LEVEL_DEPTH_DEF;
    localparam int         N_RANDOM   = 1100;
    localparam int         IDLE_LIMIT = 20000;

    typedef struct {
        logic [2:0]  status;
        logic [23:0] filled;
        logic [33:0] cost;
    } t_book_result;

    class book_scoreboard;
        int unsigned    level_q[N_LEVELS][$];
        int unsigned    total_orders;
        t_book_result   pending_q[$];
        int unsigned    errors;

        function new();
            total_orders = 0;
            errors       = 0;
        endfunction

        function void note_command(logic [1:0] cmd, logic [9:0] price,
                                   logic [23:0] amount, logic [13:0] position);
            t_book_result r;
            int unsigned  rem;
            int unsigned  take;
            longint       qty;
            longint       filled;
            longint       cost;
            r.status = ST_OK;
            filled   = 0;
            cost     = 0;
            case (cmd)
                CMD_ADD: begin
                    if (amount > AMOUNT_MAX) r.status = ST_TOOBIG;
                    else if (level_q[price].size() >= Q_DEPTH) r.status = ST_FULL;
                    else begin
                        level_q[price].push_back(amount);
                        total_orders++;
                    end
                end
                CMD_CANCEL: begin
                    if (position >= total_orders) r.status = ST_BEYOND;
                    else begin
                        rem = position;
                        for (int p = 0; p < N_LEVELS; p++) begin
                            if (rem < level_q[p].size()) begin
                                level_q[p].delete(rem);
                                total_orders--;
                                break;
                            end
                            rem -= level_q[p].size();
                        end
                    end
                end
                CMD_FILL: begin
                    qty = amount;
                    for (int p = 0; p < N_LEVELS && qty > 0; p++) begin
                        while (level_q[p].size() > 0 && qty > 0) begin
                            take = (level_q[p][0] < qty) ? level_q[p][0] : qty;
                            level_q[p][0] -= take;
                            qty    -= take;
                            filled += take;
                            cost   += longint'(take) * p;
                            if (level_q[p][0] == 0) begin
                                void'(level_q[p].pop_front());
                                total_orders--;
                            end
                        end
                    end
                    if (qty > 0) r.status = ST_EXHAUST;
                end
                default: ;
            endcase
            r.filled = filled[23:0];
            r.cost   = cost[33:0];
            pending_q.push_back(r);
        endfunction

        function void check_result(logic [2:0] status, logic [23:0] filled,
                                   logic [33:0] cost);
            t_book_result e;
            if (pending_q.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (status !== e.status) begin
                $error("status: expected %0d actual %0d", e.status, status);
                errors++;
            end
            if (filled !== e.filled) begin
                $error("filled: expected %0d actual %0d", e.filled, filled);
                errors++;
            end
            if (cost !== e.cost) begin
                $error("cost: expected %0d actual %0d", e.cost, cost);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_command;
    logic [9:0]  i_price;
    logic [23:0] i_amount;
    logic [13:0] i_position;
    logic        o_valid;
    logic        i_ready;
    logic [2:0]  o_status;
    logic [23:0] o_filled;
    logic [33:0] o_cost;

    book_scoreboard sb;
    int unsigned    idle_cycles;
    int unsigned    stall_cnt;
    int unsigned    stall_mode;

    price_level_order_book_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_command  (i_command),
        .i_price    (i_price),
        .i_amount   (i_amount),
        .i_position (i_position),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_status   (o_status),
        .o_filled   (o_filled),
        .o_cost     (o_cost)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic send_word(logic [1:0] cmd, logic [9:0] price,
                             logic [23:0] amount, logic [13:0] position);
        i_valid    <= 1'b1;
        i_command  <= cmd;
        i_price    <= price;
        i_amount   <= amount;
        i_position <= position;
        forever begin
            @(posedge i_clk);
            if (o_ready) break;
        end
        sb.note_command(cmd, price, amount, position);
    endtask

    task automatic idle_gap(int unsigned cycles);
        if (cycles > 0) begin
            i_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    task automatic send_random_word();
        logic [1:0]  cmd;
        logic [9:0]  price;
        logic [23:0] amount;
        logic [13:0] position;
        int unsigned pick;
        pick     = $urandom_range(0, 99);
        price    = $urandom_range(0, 3) == 0 ? 10'($urandom) : 10'($urandom_range(0, 40));
        amount   = 24'($urandom_range(0, 2000));
        position = 14'($urandom_range(0, sb.total_orders + 2));
        if (sb.total_orders > 90) pick = 55 + pick % 45;
        if (pick < 55) begin
            cmd = CMD_ADD;
            case ($urandom_range(0, 19))
                0: amount = 24'($urandom);
                1: amount = 24'($urandom_range(0, 65535));
                2: amount = 24'd0;
                default: ;
            endcase
        end else if (pick < 80) begin
            cmd = CMD_CANCEL;
            if ($urandom_range(0, 9) == 0) position = 14'($urandom);
        end else if (pick < 98) begin
            cmd = CMD_FILL;
            if ($urandom_range(0, 14) == 0) amount = 24'($urandom);
        end else begin
            cmd = CMD_NONE;
            price    = 10'($urandom);
            amount   = 24'($urandom);
            position = 14'($urandom);
        end
        send_word(cmd, price, amount, position);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) sb.check_result(o_status, o_filled, o_cost);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
        if (stall_cnt == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_cnt  <= $urandom_range(16, 200);
        end else begin
            stall_cnt <= stall_cnt - 1;
        end
        case (stall_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= $urandom_range(0, 1);
            2: i_ready <= ($urandom_range(0, 7) == 0);
            default: i_ready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    initial begin
        sb          = new();
        idle_cycles = 0;
        stall_cnt   = 0;
        stall_mode  = 0;
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_ready    <= 1'b0;
        i_command  <= CMD_ADD;
        i_price    <= '0;
        i_amount   <= '0;
        i_position <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(CMD_ADD, 10'd0, 24'd0, 14'd0);
        send_word(CMD_ADD, 10'd1023, 24'd65535, 14'h3FFF);
        send_word(CMD_ADD, 10'd3, 24'hFFFFFF, 14'd0);
        send_word(CMD_ADD, 10'd3, 24'd65536, 14'd0);
        send_word(CMD_CANCEL, 10'd0, 24'd0, 14'h3FFF);
        send_word(CMD_CANCEL, 10'h3FF, 24'hFFFFFF, 14'd2);
        send_word(CMD_FILL, 10'd0, 24'd0, 14'd0);
        send_word(CMD_NONE, 10'h3FF, 24'hFFFFFF, 14'h3FFF);
        send_word(CMD_FILL, 10'd0, 24'd1, 14'd0);
        send_word(CMD_FILL, 10'd0, 24'hFFFFFF, 14'd0);
        for (int k = 0; k <= Q_DEPTH; k++) send_word(CMD_ADD, 10'd7, 24'(k + 1), 14'd0);
        send_word(CMD_CANCEL, 10'd0, 24'd0, 14'd0);
        send_word(CMD_FILL, 10'd0, 24'd135, 14'd0);

        for (int n = 0; n < N_RANDOM; n++) begin
            if ($urandom_range(0, 7) == 0) idle_gap($urandom_range(1, 30));
            if (n == N_RANDOM / 2) begin
                i_valid <= 1'b0;
                while (sb.pending_q.size() != 0) @(posedge i_clk);
            end
            send_random_word();
        end
        i_valid <= 1'b0;

        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
